### rtl/clas_pkg.sv
// command line argument splitter: shared types and constants
// result kinds, error codes, character codes and controller/datapath link structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package clas_pkg;

  localparam int CharW = 16;
  localparam int IdxW  = 12;

  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_ARG_END  = 2'd1;
  localparam logic [1:0] KIND_LINE_END = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_BSLASH  = 2'd1;
  localparam logic [1:0] ERR_ARGS    = 2'd2;

  localparam logic [CharW-1:0] CH_NUL    = 16'h0000;
  localparam logic [CharW-1:0] CH_QUOTE  = 16'h0022;
  localparam logic [CharW-1:0] CH_BSLASH = 16'h005C;
  localparam logic [CharW-1:0] CH_SPACE  = 16'h0020;
  localparam logic [CharW-1:0] CH_TAB    = 16'h0009;

  // which part of the held plan is put on the output
  localparam logic [1:0] SEL_BS = 2'd0;
  localparam logic [1:0] SEL_T0 = 2'd1;
  localparam logic [1:0] SEL_T1 = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       emit;
    logic [1:0] sel;
    logic       last;
  } clas_cmd_t;

  typedef struct packed {
    logic       bs_more;
    logic [1:0] ntail;
    logic       nxt_bs_nz;
    logic [1:0] nxt_ntail;
  } clas_status_t;

  function automatic logic is_white(input logic [CharW-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

`default_nettype wire

### rtl/clas_dp.sv
// command line argument splitter datapath: parse state, per-transfer plan, output register
// depends on clas_pkg
`timescale 1ns / 1ps
`default_nettype none

module clas_dp #(
  parameter int MAX_ARGS    = 4096,
  parameter int MAX_PENDING = 32
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire [clas_pkg::CharW-1:0]  char_code_i,
  input  clas_pkg::clas_cmd_t        cmd_i,
  output clas_pkg::clas_status_t     status_o,
  output logic [1:0]                 kind_o,
  output logic [clas_pkg::CharW-1:0] out_char_o,
  output logic [clas_pkg::IdxW-1:0]  arg_index_o,
  output logic [1:0]                 error_o,
  output logic                       last_o
);

  localparam int CntW  = $clog2(MAX_ARGS + 1);
  localparam int PendW = $clog2(MAX_PENDING + 1);
  localparam int IdxExtW = (CntW > clas_pkg::IdxW) ? CntW : clas_pkg::IdxW;

  localparam logic [2:0] PH_LINE = 3'd0;
  localparam logic [2:0] PH_EXEQ = 3'd1;
  localparam logic [2:0] PH_EXEP = 3'd2;
  localparam logic [2:0] PH_SKIP = 3'd3;
  localparam logic [2:0] PH_ARG  = 3'd4;
  localparam logic [2:0] PH_HALT = 3'd5;

  logic [2:0]       ph_q, ph_d;
  logic [1:0]       qc_q, qc_d;
  logic             iqr_q, iqr_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [1:0]       err_q, err_d;

  // plan of one transfer
  logic [PendW-1:0]           bs_q, bs_d;
  logic [1:0]                 nt_q, nt_d;
  logic [1:0]                 t0k_q, t0k_d;
  logic [clas_pkg::CharW-1:0] t0c_q, t0c_d;
  logic [1:0]                 t1k_q, t1k_d;
  logic [clas_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [1:0]                 perr_q;

  logic [CntW-1:0]    icnt;
  logic [CntW-1:0]    icnt_m1;
  logic [IdxExtW-1:0] idx_ext;
  logic [1:0]         aq;
  logic               ai;
  logic [PendW-1:0]   ap;
  logic               do_arg;
  logic               restart;
  logic               c_zero, c_quote, c_bs, c_white, cnt_full;

  logic [1:0]                 kind_q;
  logic [clas_pkg::CharW-1:0] out_char_q;
  logic [clas_pkg::IdxW-1:0]  arg_index_q;
  logic [1:0]                 error_q;
  logic                       last_q;

  assign c_zero   = (char_code_i == clas_pkg::CH_NUL);
  assign c_quote  = (char_code_i == clas_pkg::CH_QUOTE);
  assign c_bs     = (char_code_i == clas_pkg::CH_BSLASH);
  assign c_white  = clas_pkg::is_white(char_code_i);
  assign cnt_full = (cnt_q >= CntW'(MAX_ARGS));

  always_comb begin
    ph_d    = ph_q;
    qc_d    = qc_q;
    iqr_d   = iqr_q;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    icnt    = cnt_q;
    bs_d    = '0;
    nt_d    = 2'd0;
    t0k_d   = clas_pkg::KIND_CHAR;
    t0c_d   = clas_pkg::CH_NUL;
    t1k_d   = clas_pkg::KIND_LINE_END;
    do_arg  = 1'b0;
    restart = 1'b0;
    aq      = qc_q;
    ai      = iqr_q;
    ap      = pend_q;

    case (ph_q)
      PH_LINE: begin
        if (cnt_full) begin
          err_d = clas_pkg::ERR_ARGS;
          ph_d  = PH_HALT;
          nt_d  = 2'd1;
          t0k_d = clas_pkg::KIND_LINE_END;
        end else begin
          icnt  = cnt_q + CntW'(1);
          cnt_d = icnt;
          if (c_zero) begin
            nt_d    = 2'd2;
            t0k_d   = clas_pkg::KIND_ARG_END;
            restart = 1'b1;
          end else if (c_quote) begin
            ph_d = PH_EXEQ;
          end else if (c_white) begin
            nt_d  = 2'd1;
            t0k_d = clas_pkg::KIND_ARG_END;
            ph_d  = PH_SKIP;
          end else begin
            nt_d  = 2'd1;
            t0c_d = char_code_i;
            ph_d  = PH_EXEP;
          end
        end
      end
      PH_EXEQ, PH_EXEP: begin
        if (c_zero) begin
          nt_d    = 2'd2;
          t0k_d   = clas_pkg::KIND_ARG_END;
          restart = 1'b1;
        end else if ((ph_q == PH_EXEQ) ? c_quote : c_white) begin
          nt_d  = 2'd1;
          t0k_d = clas_pkg::KIND_ARG_END;
          ph_d  = PH_SKIP;
        end else begin
          nt_d  = 2'd1;
          t0c_d = char_code_i;
        end
      end
      PH_SKIP: begin
        if (c_zero) begin
          nt_d    = 2'd1;
          t0k_d   = clas_pkg::KIND_LINE_END;
          restart = 1'b1;
        end else if (!c_white) begin
          if (cnt_full) begin
            err_d = clas_pkg::ERR_ARGS;
            ph_d  = PH_HALT;
            nt_d  = 2'd1;
            t0k_d = clas_pkg::KIND_LINE_END;
          end else begin
            icnt   = cnt_q + CntW'(1);
            cnt_d  = icnt;
            aq     = 2'd0;
            ai     = 1'b0;
            ap     = '0;
            ph_d   = PH_ARG;
            do_arg = 1'b1;
          end
        end
      end
      PH_ARG: begin
        do_arg = 1'b1;
      end
      default: begin
        if (c_zero) begin
          nt_d  = 2'd1;
          t0k_d = clas_pkg::KIND_LINE_END;
        end
      end
    endcase

    if (do_arg) begin
      if (ai && !c_quote) begin
        if (aq == 2'd2) begin
          aq = 2'd0;
        end
        ai = 1'b0;
      end
      if (c_zero) begin
        bs_d    = ap;
        nt_d    = 2'd2;
        t0k_d   = clas_pkg::KIND_ARG_END;
        restart = 1'b1;
      end else if (ai) begin
        aq = aq + 2'd1;
        if (aq == 2'd3) begin
          nt_d  = 2'd1;
          t0c_d = clas_pkg::CH_QUOTE;
          aq    = 2'd0;
        end
      end else if (c_white && (aq == 2'd0)) begin
        bs_d  = ap;
        ap    = '0;
        nt_d  = 2'd1;
        t0k_d = clas_pkg::KIND_ARG_END;
        ph_d  = PH_SKIP;
      end else if (c_bs) begin
        if (ap >= PendW'(MAX_PENDING)) begin
          err_d = clas_pkg::ERR_BSLASH;
          ph_d  = PH_HALT;
          nt_d  = 2'd1;
          t0k_d = clas_pkg::KIND_LINE_END;
        end else begin
          ap = ap + PendW'(1);
        end
      end else if (c_quote) begin
        bs_d = ap >> 1;
        if (ap[0]) begin
          nt_d  = 2'd1;
          t0c_d = clas_pkg::CH_QUOTE;
        end else begin
          aq = aq + 2'd1;
        end
        ap = '0;
        ai = 1'b1;
      end else begin
        bs_d  = ap;
        ap    = '0;
        nt_d  = 2'd1;
        t0c_d = char_code_i;
      end
      qc_d   = aq;
      iqr_d  = ai;
      pend_d = ap;
    end

    if (restart) begin
      ph_d   = PH_LINE;
      qc_d   = 2'd0;
      iqr_d  = 1'b0;
      pend_d = '0;
      cnt_d  = '0;
    end
  end

  assign icnt_m1 = (icnt != '0) ? (icnt - CntW'(1)) : '0;
  assign idx_ext = IdxExtW'(icnt_m1);
  assign idx_d   = idx_ext[clas_pkg::IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_LINE;
      qc_q   <= 2'd0;
      iqr_q  <= 1'b0;
      pend_q <= '0;
      cnt_q  <= '0;
      err_q  <= clas_pkg::ERR_NONE;
      bs_q   <= '0;
      nt_q   <= 2'd0;
    end else if (cmd_i.accept) begin
      ph_q   <= ph_d;
      qc_q   <= qc_d;
      iqr_q  <= iqr_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      err_q  <= err_d;
      bs_q   <= bs_d;
      nt_q   <= nt_d;
    end else if (cmd_i.emit && (cmd_i.sel == clas_pkg::SEL_BS)) begin
      bs_q <= bs_q - PendW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      t0k_q  <= t0k_d;
      t0c_q  <= t0c_d;
      t1k_q  <= t1k_d;
      idx_q  <= idx_d;
      perr_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      arg_index_q <= idx_q;
      error_q     <= perr_q;
      last_q      <= cmd_i.last;
      case (cmd_i.sel)
        clas_pkg::SEL_BS: begin
          kind_q     <= clas_pkg::KIND_CHAR;
          out_char_q <= clas_pkg::CH_BSLASH;
        end
        clas_pkg::SEL_T0: begin
          kind_q     <= t0k_q;
          out_char_q <= t0c_q;
        end
        default: begin
          kind_q     <= t1k_q;
          out_char_q <= clas_pkg::CH_NUL;
        end
      endcase
    end
  end

  assign status_o.bs_more   = (bs_q > PendW'(1));
  assign status_o.ntail     = nt_q;
  assign status_o.nxt_bs_nz = (bs_d != '0);
  assign status_o.nxt_ntail = nt_d;

  assign kind_o      = kind_q;
  assign out_char_o  = out_char_q;
  assign arg_index_o = arg_index_q;
  assign error_o     = error_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### rtl/clas_ctrl.sv
// command line argument splitter controller: input/output handshakes and result sequencing
// depends on clas_pkg
`timescale 1ns / 1ps
`default_nettype none

module clas_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  input  clas_pkg::clas_status_t status_i,
  output clas_pkg::clas_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BS   = 2'd1;
  localparam logic [1:0] ST_T0   = 2'd2;
  localparam logic [1:0] ST_T1   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       load;
  logic       emit;
  logic       final_res;
  logic       ready;
  logic       accept;
  logic [1:0] sel;
  logic [1:0] after_emit;
  logic [1:0] first_st;

  // output register free this cycle
  assign load = !out_valid_q || !out_stall_i;
  assign emit = load && (state_q != ST_IDLE);

  always_comb begin
    sel        = clas_pkg::SEL_T1;
    final_res  = 1'b1;
    after_emit = ST_IDLE;
    case (state_q)
      ST_BS: begin
        sel       = clas_pkg::SEL_BS;
        final_res = !status_i.bs_more && (status_i.ntail == 2'd0);
        if (status_i.bs_more) begin
          after_emit = ST_BS;
        end else if (status_i.ntail != 2'd0) begin
          after_emit = ST_T0;
        end
      end
      ST_T0: begin
        sel       = clas_pkg::SEL_T0;
        final_res = (status_i.ntail == 2'd1);
        if (status_i.ntail != 2'd1) begin
          after_emit = ST_T1;
        end
      end
      ST_T1: begin
        sel = clas_pkg::SEL_T1;
      end
      default: begin
        sel = clas_pkg::SEL_T1;
      end
    endcase
  end

  assign ready  = (state_q == ST_IDLE) || (emit && final_res);
  assign accept = in_valid_i && ready;

  always_comb begin
    if (status_i.nxt_bs_nz) begin
      first_st = ST_BS;
    end else if (status_i.nxt_ntail != 2'd0) begin
      first_st = ST_T0;
    end else begin
      first_st = ST_IDLE;
    end
  end

  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = first_st;
    end else if (emit) begin
      state_d = after_emit;
    end
  end

  assign out_valid_d = emit ? 1'b1 : (load ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o.accept = accept;
  assign cmd_o.emit   = emit;
  assign cmd_o.sel    = sel;
  assign cmd_o.last   = final_res;

  assign in_stall_o  = !ready;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/command_line_argument_splitter_core.sv
// command line argument splitter top level: controller plus datapath
// depends on clas_pkg, clas_ctrl, clas_dp
//
// usage
//   input channel: one 16-bit character per transfer (in_valid_i / in_stall_o);
//   code 0 ends the line. output channel: one result per transfer
//   (out_valid_o / out_stall_i) with kind, out_char, arg_index, error and last;
//   last marks the final result caused by one input character.
// timing
//   a character's results are loaded into the output register one per cycle
//   while out_stall_i is low. a character with no results leaves the block
//   idle; otherwise the next character is taken in the cycle its final
//   result is loaded, so single-result characters stream at one per cycle
//   while the output is not stalled. a held backslash run of up to MAX_PENDING
//   adds one backslash result per backslash, half of them before a quote.
// reset
//   rst_ni clears the parse state, argument count and sticky error; the block
//   then waits at line start with the output register empty.
// stall
//   while out_stall_i is high the current result holds; the input stalls while
//   results of an accepted character wait behind it.
`timescale 1ns / 1ps
`default_nettype none

module command_line_argument_splitter_core #(
  parameter int MAX_ARGS    = 4096,
  parameter int MAX_PENDING = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [15:0] char_code_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] out_char_o,
  output logic [11:0] arg_index_o,
  output logic [1:0]  error_o,
  output logic        last_o
);

  clas_pkg::clas_cmd_t    cmd;
  clas_pkg::clas_status_t status;

  clas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  clas_dp #(
    .MAX_ARGS    (MAX_ARGS),
    .MAX_PENDING (MAX_PENDING)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_code_i (char_code_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .kind_o      (kind_o),
    .out_char_o  (out_char_o),
    .arg_index_o (arg_index_o),
    .error_o     (error_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
